[design/chte_pkg.sv]
// Shared types, codes and default sizes of the chained hash table engine.
package chte_pkg;

	localparam int MAX_BUCKETS_D = 16;
	localparam int KEY_BYTES_D   = 19;
	localparam int ENTRIES_D     = 64;

	localparam logic [31:0] HASH_SEED  = 32'd5381;
	localparam int          HASH_SHIFT = 5;

	// Dividend bits consumed per cycle by the modulo unit.
	localparam int MOD_BITS = 4;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_TOO_LONG  = 3'd6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  key_byte;
		logic        key_last;
		logic [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  bucket;
		logic [31:0] found_value;
		logic [6:0]  entries;
	} res_word_t;

endpackage

[design/chte_mod.sv]
// Iterative remainder unit: dividend modulo a small divisor, MOD_BITS dividend bits per cycle.
module chte_mod #(
	parameter int DW = 32,
	parameter int RW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [RW-1:0] divisor,
	output logic          done,
	output logic [RW-1:0] rem
);

	localparam int STEPS = DW / chte_pkg::MOD_BITS;
	localparam int CW    = $clog2(STEPS + 1);

	logic [DW-1:0] dvd_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [RW-1:0] rem_nxt;

	always_comb begin
		logic [RW:0] r2;
		r2 = '0;
		rem_nxt = rem_q;
		for (int k = 0; k < chte_pkg::MOD_BITS; k++) begin
			r2 = {rem_nxt, dvd_q[DW-1-k]};
			if (r2 >= {1'b0, dsr_q}) begin
				r2 = r2 - {1'b0, dsr_q};
			end
			rem_nxt = r2[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << chte_pkg::MOD_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[design/chained_hash_table_engine.sv]
// Chained hash table engine: streams key bytes, hashes them, runs table commands.
// Key bytes that are not last are taken while idle; a last byte holds busy through the modulo, then
// a check and a compare per chain entry, a check when the walk ends without a match and an act
// step, plus a free map search of eight slots per step for a new key; an over-long key stops after
// the modulo. Reset at once empties the chain heads, marks every slot free, clears the entry count
// and the key state. Done is high for one cycle as busy drops; the receiver cannot stall the block.
module chained_hash_table_engine #(
	parameter int MAX_BUCKETS = chte_pkg::MAX_BUCKETS_D,
	parameter int KEY_BYTES   = chte_pkg::KEY_BYTES_D,
	parameter int ENTRIES     = chte_pkg::ENTRIES_D
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [4:0]          cfg_data,
	input  logic                start,
	output logic                busy,
	input  chte_pkg::in_word_t  item,
	output logic                done,
	output chte_pkg::res_word_t result
);

	// Index widths. A slot index one past the last entry marks an empty link.
	localparam int IW   = $clog2(ENTRIES + 1);
	localparam int SW   = $clog2(ENTRIES);
	localparam int BKW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int BW   = $clog2(MAX_BUCKETS + 1);
	localparam int LW   = $clog2(KEY_BYTES + 1);
	localparam int KBW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KW   = KEY_BYTES * 8;
	localparam int NGRP = (ENTRIES + 7) / 8;
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam logic [IW-1:0] NULL_IDX = IW'(ENTRIES);

	typedef struct packed {
		logic [KW-1:0] key;
		logic [LW-1:0] len;
		logic [IW-1:0] next;
		logic [31:0]   value;
	} row_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MOD  = 6'b000010,
		S_CHK  = 6'b000100,
		S_CMP  = 6'b001000,
		S_ACT  = 6'b010000,
		S_FREE = 6'b100000
	} state_t;

	state_t state_q;

	// Key accumulation.
	logic [31:0]   acc_q;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic [7:0]    kbuf_q [KEY_BYTES];
	logic [31:0]   hash_nxt;

	// Command in flight.
	logic [1:0]    cmd_q;
	logic [31:0]   val_q;
	logic [LW-1:0] klen_q;
	logic          kovf_q;
	logic [BKW-1:0] bucket_q;
	logic [3:0]    bucket_out_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] steps_q;
	logic [GW-1:0] grp_q;
	row_t          prev_row_q;

	// Table state.
	logic [4:0]         nbk_q;
	logic [IW-1:0]      heads_q [MAX_BUCKETS];
	logic [ENTRIES-1:0] free_q;
	logic [IW-1:0]      count_q;
	row_t               mem_q [ENTRIES];
	row_t               rd_row_q;

	// Memory write port.
	logic          mem_we;
	logic [SW-1:0] mem_wa;
	row_t          mem_wd;

	logic          mod_done;
	logic [BW-1:0] mod_rem;
	logic [BW-1:0] nb_eff;
	logic          accept;
	logic          key_match;
	logic          free_hit;
	logic [SW-1:0] free_idx;
	logic [KW-1:0] key_row;

	logic          done_q;
	chte_pkg::res_word_t res_q;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign hash_nxt = acc_q + (acc_q << chte_pkg::HASH_SHIFT) + {24'd0, item.key_byte};

	// A register value of zero acts as one bucket; values above the limit clamp to it.
	always_comb begin
		if (nbk_q == 5'd0) begin
			nb_eff = BW'(1);
		end else if (int'(nbk_q) > MAX_BUCKETS) begin
			nb_eff = BW'(MAX_BUCKETS);
		end else begin
			nb_eff = BW'(nbk_q);
		end
	end

	chte_mod #(
		.DW (32),
		.RW (BW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && item.key_last),
		.dividend (hash_nxt),
		.divisor  (nb_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		for (int j = 0; j < KEY_BYTES; j++) begin
			key_row[j*8 +: 8] = kbuf_q[j];
		end
	end

	// Keys match when lengths agree and every byte below that length agrees.
	always_comb begin
		key_match = (rd_row_q.len == klen_q);
		for (int j = 0; j < KEY_BYTES; j++) begin
			if (LW'(j) < klen_q && rd_row_q.key[j*8 +: 8] != kbuf_q[j]) begin
				key_match = 1'b0;
			end
		end
	end

	// Looks at eight slots of the free map per cycle; the lowest free slot wins.
	always_comb begin
		int idx;
		free_hit = 1'b0;
		free_idx = '0;
		for (int k = 7; k >= 0; k--) begin
			idx = int'(grp_q) * 8 + k;
			if (idx < ENTRIES && free_q[SW'(idx)]) begin
				free_hit = 1'b1;
				free_idx = SW'(idx);
			end
		end
	end

	// Every write to the entry memory happens in the act or free-search step.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_q[SW-1:0];
		mem_wd = rd_row_q;
		if (state_q == S_ACT && cur_q != NULL_IDX) begin
			if (cmd_q == chte_pkg::CMD_INSERT) begin
				mem_we       = 1'b1;
				mem_wd.value = val_q;
			end else if (cmd_q == chte_pkg::CMD_DELETE && prev_q != NULL_IDX) begin
				mem_we      = 1'b1;
				mem_wa      = prev_q[SW-1:0];
				mem_wd      = prev_row_q;
				mem_wd.next = rd_row_q.next;
			end
		end else if (state_q == S_FREE && free_hit) begin
			mem_we       = 1'b1;
			mem_wa       = free_idx;
			mem_wd.key   = key_row;
			mem_wd.len   = klen_q;
			mem_wd.next  = heads_q[bucket_q];
			mem_wd.value = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_row_q <= mem_q[cur_q[SW-1:0]];
	end

	// Key buffer and command payload need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (len_q < LW'(KEY_BYTES)) begin
				kbuf_q[len_q[KBW-1:0]] <= item.key_byte;
			end
			if (item.key_last) begin
				cmd_q  <= item.cmd;
				val_q  <= item.value;
				klen_q <= (len_q < LW'(KEY_BYTES)) ? len_q + 1'b1 : len_q;
				kovf_q <= ovf_q || (len_q >= LW'(KEY_BYTES));
			end
		end
		if (state_q == S_CMP && !key_match) begin
			prev_row_q <= rd_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			acc_q        <= chte_pkg::HASH_SEED;
			len_q        <= '0;
			ovf_q        <= 1'b0;
			nbk_q        <= 5'd16;
			free_q       <= '1;
			count_q      <= '0;
			cur_q        <= NULL_IDX;
			prev_q       <= NULL_IDX;
			steps_q      <= '0;
			grp_q        <= '0;
			bucket_q     <= '0;
			bucket_out_q <= '0;
			done_q       <= 1'b0;
			res_q        <= '0;
			for (int b = 0; b < MAX_BUCKETS; b++) begin
				heads_q[b] <= NULL_IDX;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				nbk_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.key_last) begin
							// The key state returns to its seed; the op works from copies.
							acc_q   <= chte_pkg::HASH_SEED;
							len_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_MOD;
						end else begin
							acc_q <= hash_nxt;
							if (len_q < LW'(KEY_BYTES)) begin
								len_q <= len_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						bucket_q     <= BKW'(mod_rem);
						bucket_out_q <= 4'(mod_rem);
						cur_q        <= heads_q[BKW'(mod_rem)];
						prev_q       <= NULL_IDX;
						steps_q      <= '0;
						if (kovf_q) begin
							res_q.status      <= chte_pkg::ST_TOO_LONG;
							res_q.bucket      <= 4'(mod_rem);
							res_q.found_value <= '0;
							res_q.entries     <= 7'(count_q);
							done_q            <= 1'b1;
							state_q           <= S_IDLE;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (cur_q == NULL_IDX || steps_q == IW'(ENTRIES)) begin
						cur_q   <= NULL_IDX;
						state_q <= S_ACT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_match) begin
						state_q <= S_ACT;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd_row_q.next;
						steps_q <= steps_q + 1'b1;
						state_q <= S_CHK;
					end
				end
				S_ACT: begin
					res_q.bucket      <= bucket_out_q;
					res_q.found_value <= '0;
					res_q.entries     <= 7'(count_q);
					done_q            <= 1'b1;
					state_q           <= S_IDLE;
					case (cmd_q)
						chte_pkg::CMD_INSERT: begin
							if (cur_q != NULL_IDX) begin
								res_q.status <= chte_pkg::ST_UPDATED;
							end else begin
								// New key: look for a free slot first.
								done_q  <= 1'b0;
								grp_q   <= '0;
								state_q <= S_FREE;
							end
						end
						chte_pkg::CMD_DELETE: begin
							if (cur_q != NULL_IDX) begin
								if (prev_q == NULL_IDX) begin
									heads_q[bucket_q] <= rd_row_q.next;
								end
								free_q[cur_q[SW-1:0]] <= 1'b1;
								if (count_q != '0) begin
									count_q       <= count_q - 1'b1;
									res_q.entries <= 7'(count_q - 1'b1);
								end
								res_q.status <= chte_pkg::ST_DELETED;
							end else begin
								res_q.status <= chte_pkg::ST_NOT_FOUND;
							end
						end
						default: begin
							// Search, and the unused code behaves the same way.
							if (cur_q != NULL_IDX) begin
								res_q.status      <= chte_pkg::ST_FOUND;
								res_q.found_value <= rd_row_q.value;
							end else begin
								res_q.status <= chte_pkg::ST_NOT_FOUND;
							end
						end
					endcase
				end
				S_FREE: begin
					res_q.bucket      <= bucket_out_q;
					res_q.found_value <= '0;
					if (free_hit) begin
						free_q[free_idx]  <= 1'b0;
						heads_q[bucket_q] <= IW'(free_idx);
						count_q           <= count_q + 1'b1;
						res_q.status      <= chte_pkg::ST_INSERTED;
						res_q.entries     <= 7'(count_q + 1'b1);
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else if (grp_q == GW'(NGRP - 1)) begin
						res_q.status  <= chte_pkg::ST_FULL;
						res_q.entries <= 7'(count_q);
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						grp_q <= grp_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
